// ----- design/cfsuv_pkg.sv -----
// cfsuv_pkg: shared constants and types for the cube map face select unit
// no dependencies; imported by every module of the block

package cfsuv_pkg;

   // default field widths
   localparam int CFSUV_COMPONENT_BITS = 16;
   localparam int CFSUV_COORD_BITS     = 16;

   localparam int FACE_BITS  = 3;
   localparam int LANE_COUNT = 2;
   localparam int LANE_U     = 0;
   localparam int LANE_V     = 1;

   typedef enum logic [FACE_BITS-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   // per-word side information that rides along the divider stages
   typedef struct packed {
      face_type face;
      logic     zero;
   } side_type;

endpackage

// ----- design/cfsuv_axis.sv -----
// cfsuv_axis: first pipeline stage, major axis pick, face code and ratio operands
// depends on cfsuv_pkg

module cfsuv_axis
   import cfsuv_pkg::*;
#(
   parameter int COMPONENT_BITS = CFSUV_COMPONENT_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_stall,
   input  logic [COMPONENT_BITS-1:0]                     in_dir_x,
   input  logic [COMPONENT_BITS-1:0]                     in_dir_y,
   input  logic [COMPONENT_BITS-1:0]                     in_dir_z,
   output logic                                          out_valid,
   input  logic                                          out_stall,
   output side_type                                      out_side,
   output logic [LANE_COUNT-1:0][COMPONENT_BITS:0]       out_num,
   output logic [LANE_COUNT-1:0][COMPONENT_BITS:0]       out_den
);

   localparam int CB = COMPONENT_BITS;

   logic signed [CB:0] xe, ye, ze;
   logic signed [CB:0] ax, ay, az;
   logic               sel_x, sel_y, zero;
   logic               adv;

   logic                               valid_ff;
   side_type                           side_ff, side_in;
   logic [LANE_COUNT-1:0][CB:0]        num_ff, num_in;
   logic [LANE_COUNT-1:0][CB:0]        den_ff, den_in;

   always_comb begin
      xe = $signed({in_dir_x[CB-1], in_dir_x});
      ye = $signed({in_dir_y[CB-1], in_dir_y});
      ze = $signed({in_dir_z[CB-1], in_dir_z});
      ax = xe[CB] ? -xe : xe;
      ay = ye[CB] ? -ye : ye;
      az = ze[CB] ? -ze : ze;

      // ties go to x, then y
      sel_x = (ax >= ay) && (ax >= az);
      sel_y = !sel_x && (ay >= az);
      zero  = (xe == '0) && (ye == '0) && (ze == '0);

      side_in.zero = zero;
      if (sel_x) begin
         side_in.face   = xe[CB] ? FACE_NEG_X : FACE_POS_X;
         num_in[LANE_U] = -ze;
         den_in[LANE_U] = xe;
         num_in[LANE_V] = ye;
         den_in[LANE_V] = ax;
      end else if (sel_y) begin
         side_in.face   = ye[CB] ? FACE_NEG_Y : FACE_POS_Y;
         num_in[LANE_U] = xe;
         den_in[LANE_U] = ay;
         num_in[LANE_V] = -ze;
         den_in[LANE_V] = ye;
      end else begin
         side_in.face   = ze[CB] ? FACE_NEG_Z : FACE_POS_Z;
         num_in[LANE_U] = xe;
         den_in[LANE_U] = ze;
         num_in[LANE_V] = ye;
         den_in[LANE_V] = az;
      end

      // 0/1 gives the center coordinate for the zero vector
      if (zero) begin
         num_in[LANE_U] = '0;
         den_in[LANE_U] = {{CB{1'b0}}, 1'b1};
         num_in[LANE_V] = '0;
         den_in[LANE_V] = {{CB{1'b0}}, 1'b1};
      end
   end

   assign adv      = !valid_ff || !out_stall;
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         side_ff <= side_in;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

// ----- design/cfsuv_prep.sv -----
// cfsuv_prep: second stage, sign folding and integer quotient bit of each ratio
// depends on cfsuv_pkg

module cfsuv_prep
   import cfsuv_pkg::*;
#(
   parameter int COMPONENT_BITS = CFSUV_COMPONENT_BITS,
   parameter int COORD_BITS     = CFSUV_COORD_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_stall,
   input  side_type                                      in_side,
   input  logic [LANE_COUNT-1:0][COMPONENT_BITS:0]       in_num,
   input  logic [LANE_COUNT-1:0][COMPONENT_BITS:0]       in_den,
   output logic                                          out_valid,
   input  logic                                          out_stall,
   output side_type                                      out_side,
   output logic [LANE_COUNT-1:0][COMPONENT_BITS-1:0]     out_rem,
   output logic [LANE_COUNT-1:0][COMPONENT_BITS-1:0]     out_den,
   output logic [LANE_COUNT-1:0][COORD_BITS-1:0]         out_quo,
   output logic [LANE_COUNT-1:0]                         out_sat
);

   localparam int CB = COMPONENT_BITS;
   localparam int CO = COORD_BITS;

   logic signed [CB:0]              n [LANE_COUNT];
   logic signed [CB:0]              dm [LANE_COUNT];
   logic signed [CB:0]              sum [LANE_COUNT];
   logic                            adv;

   logic                            valid_ff;
   side_type                        side_ff;
   logic [LANE_COUNT-1:0][CB-1:0]   rem_ff, rem_in;
   logic [LANE_COUNT-1:0][CB-1:0]   den_ff, den_in;
   logic [LANE_COUNT-1:0][CO-1:0]   quo_ff, quo_in;
   logic [LANE_COUNT-1:0]           sat_ff, sat_in;

   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         // fold a negative denominator into the numerator
         n[i]   = in_den[i][CB] ? -$signed(in_num[i]) : $signed(in_num[i]);
         dm[i]  = in_den[i][CB] ? -$signed(in_den[i]) : $signed(in_den[i]);
         sum[i] = n[i] + dm[i];
         // ratio of +1 saturates
         sat_in[i] = (n[i] == dm[i]);
         // integer part of (n + d) / d is 1 exactly when n is non-negative
         quo_in[i] = {{(CO-1){1'b0}}, !n[i][CB]};
         rem_in[i] = n[i][CB] ? sum[i][CB-1:0] : n[i][CB-1:0];
         den_in[i] = dm[i][CB-1:0];
      end
   end

   assign adv      = !valid_ff || !out_stall;
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         den_ff  <= den_in;
         quo_ff  <= quo_in;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_sat   = sat_ff;

endmodule

// ----- design/cfsuv_div_step.sv -----
// cfsuv_div_step: one registered restoring-division step for both coordinate lanes
// depends on cfsuv_pkg

module cfsuv_div_step
   import cfsuv_pkg::*;
#(
   parameter int COMPONENT_BITS = CFSUV_COMPONENT_BITS,
   parameter int COORD_BITS     = CFSUV_COORD_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_stall,
   input  side_type                                      in_side,
   input  logic [LANE_COUNT-1:0][COMPONENT_BITS-1:0]     in_rem,
   input  logic [LANE_COUNT-1:0][COMPONENT_BITS-1:0]     in_den,
   input  logic [LANE_COUNT-1:0][COORD_BITS-1:0]         in_quo,
   input  logic [LANE_COUNT-1:0]                         in_sat,
   output logic                                          out_valid,
   input  logic                                          out_stall,
   output side_type                                      out_side,
   output logic [LANE_COUNT-1:0][COMPONENT_BITS-1:0]     out_rem,
   output logic [LANE_COUNT-1:0][COMPONENT_BITS-1:0]     out_den,
   output logic [LANE_COUNT-1:0][COORD_BITS-1:0]         out_quo,
   output logic [LANE_COUNT-1:0]                         out_sat
);

   localparam int CB = COMPONENT_BITS;
   localparam int CO = COORD_BITS;

   logic [CB:0]                     r2 [LANE_COUNT];
   logic [CB:0]                     d2 [LANE_COUNT];
   logic [CB:0]                     diff [LANE_COUNT];
   logic                            ge [LANE_COUNT];
   logic                            adv;

   logic                            valid_ff;
   side_type                        side_ff;
   logic [LANE_COUNT-1:0][CB-1:0]   rem_ff, rem_in;
   logic [LANE_COUNT-1:0][CB-1:0]   den_ff;
   logic [LANE_COUNT-1:0][CO-1:0]   quo_ff, quo_in;
   logic [LANE_COUNT-1:0]           sat_ff;

   always_comb begin
      for (int i = 0; i < LANE_COUNT; i++) begin
         r2[i]     = {in_rem[i], 1'b0};
         d2[i]     = {1'b0, in_den[i]};
         diff[i]   = r2[i] - d2[i];
         ge[i]     = (r2[i] >= d2[i]);
         rem_in[i] = ge[i] ? diff[i][CB-1:0] : r2[i][CB-1:0];
         quo_in[i] = {in_quo[i][CO-2:0], ge[i]};
      end
   end

   assign adv      = !valid_ff || !out_stall;
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         sat_ff  <= in_sat;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_sat   = sat_ff;

endmodule

// ----- design/cubemap_face_select_uv_unit.sv -----
// cubemap_face_select_uv_unit: cube map face selection with face coordinates
// depends on cfsuv_pkg, cfsuv_axis, cfsuv_prep, cfsuv_div_step
//
// usage
//   req channel takes one direction word (dir_x, dir_y, dir_z, signed) when
//   req_valid is high and req_stall is low; rsp channel gives face, coord_u,
//   coord_v and zero_dir when rsp_valid is high, taken when rsp_stall is low
//   the path from acceptance to rsp_valid is one axis stage, one sign-folding
//   stage that also yields the integer quotient bit, then one restoring-division
//   stage per fraction bit of the coordinates, both coordinates side by side
//   throughput is one word per cycle while rsp_stall stays low, set by the
//   one-step-per-stage divider
//   every stage has its own valid bit, so bubbles close up under a stall and
//   words keep entering until the pipeline is full; req_stall rises only when
//   every stage holds a word and rsp_stall is high
//   reset clears all valid bits; no words are in flight after reset
//   the zero vector gives face +x, zero_dir high and both coordinates at half

module cubemap_face_select_uv_unit
   import cfsuv_pkg::*;
#(
   parameter int COMPONENT_BITS = CFSUV_COMPONENT_BITS,
   parameter int COORD_BITS     = CFSUV_COORD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [COMPONENT_BITS-1:0] req_dir_x,
   input  logic [COMPONENT_BITS-1:0] req_dir_y,
   input  logic [COMPONENT_BITS-1:0] req_dir_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [FACE_BITS-1:0]      rsp_face,
   output logic [COORD_BITS-1:0]     rsp_coord_u,
   output logic [COORD_BITS-1:0]     rsp_coord_v,
   output logic                      rsp_zero_dir
);

   localparam int CB    = COMPONENT_BITS;
   localparam int CO    = COORD_BITS;
   // one division stage per fraction bit
   localparam int STEPS = COORD_BITS - 1;

   // axis stage to prep stage
   logic                              ax_valid;
   logic                              ax_stall;
   side_type                          ax_side;
   logic [LANE_COUNT-1:0][CB:0]       ax_num;
   logic [LANE_COUNT-1:0][CB:0]       ax_den;

   // divider pipe, index 0 is the prep stage output
   logic                              dv_valid [STEPS+1];
   logic                              dv_stall [STEPS+1];
   side_type                          dv_side  [STEPS+1];
   logic [LANE_COUNT-1:0][CB-1:0]     dv_rem   [STEPS+1];
   logic [LANE_COUNT-1:0][CB-1:0]     dv_den   [STEPS+1];
   logic [LANE_COUNT-1:0][CO-1:0]     dv_quo   [STEPS+1];
   logic [LANE_COUNT-1:0]             dv_sat   [STEPS+1];

   // major axis, face and ratio operands
   cfsuv_axis #(
      .COMPONENT_BITS (COMPONENT_BITS)
   ) u_axis (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_dir_x  (req_dir_x),
      .in_dir_y  (req_dir_y),
      .in_dir_z  (req_dir_z),
      .out_valid (ax_valid),
      .out_stall (ax_stall),
      .out_side  (ax_side),
      .out_num   (ax_num),
      .out_den   (ax_den)
   );

   // denominator made positive, integer bit and saturation flag
   cfsuv_prep #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .COORD_BITS     (COORD_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ax_valid),
      .in_stall  (ax_stall),
      .in_side   (ax_side),
      .in_num    (ax_num),
      .in_den    (ax_den),
      .out_valid (dv_valid[0]),
      .out_stall (dv_stall[0]),
      .out_side  (dv_side[0]),
      .out_rem   (dv_rem[0]),
      .out_den   (dv_den[0]),
      .out_quo   (dv_quo[0]),
      .out_sat   (dv_sat[0])
   );

   // one fraction bit per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      cfsuv_div_step #(
         .COMPONENT_BITS (COMPONENT_BITS),
         .COORD_BITS     (COORD_BITS)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[k]),
         .in_stall  (dv_stall[k]),
         .in_side   (dv_side[k]),
         .in_rem    (dv_rem[k]),
         .in_den    (dv_den[k]),
         .in_quo    (dv_quo[k]),
         .in_sat    (dv_sat[k]),
         .out_valid (dv_valid[k+1]),
         .out_stall (dv_stall[k+1]),
         .out_side  (dv_side[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_den   (dv_den[k+1]),
         .out_quo   (dv_quo[k+1]),
         .out_sat   (dv_sat[k+1])
      );
   end

   // last stage is the output register; saturation picks all ones
   assign dv_stall[STEPS] = rsp_stall;
   assign rsp_valid       = dv_valid[STEPS];
   assign rsp_face        = dv_side[STEPS].face;
   assign rsp_zero_dir    = dv_side[STEPS].zero;
   assign rsp_coord_u     = dv_sat[STEPS][LANE_U] ? {CO{1'b1}} : dv_quo[STEPS][LANE_U];
   assign rsp_coord_v     = dv_sat[STEPS][LANE_V] ? {CO{1'b1}} : dv_quo[STEPS][LANE_V];

`ifndef SYNTHESIS
   // a zero vector always leaves as +x with centered coordinates
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_dir |->
         rsp_face == FACE_POS_X && rsp_coord_u == {1'b1, {(CO-1){1'b0}}} &&
         rsp_coord_v == {1'b1, {(CO-1){1'b0}}})
      else $error("zero vector word has wrong face or coordinates");

   // with the output free, every stage advances and the input is never held
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");
`endif

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for cubemap_face_select_uv_unit
// depends on cfsuv_pkg and the unit's rtl; predicts face and coordinates per word
// and drives both channels with changing idle and stall patterns

`timescale 1ns / 1ps

module tb_top
   import cfsuv_pkg::*;
();

   localparam int COMPONENT_BITS = CFSUV_COMPONENT_BITS;
   localparam int COORD_BITS     = CFSUV_COORD_BITS;
   // number of stages from acceptance to rsp_valid: axis, prep and one per fraction bit
   localparam int PIPE_DEPTH     = COORD_BITS + 1;
   localparam int RANDOM_WORDS   = 1400;

   typedef logic signed [COMPONENT_BITS-1:0] comp_type;
   typedef logic [COORD_BITS-1:0]            coord_type;

   // one expected result word
   typedef struct {
      face_type  face;
      coord_type coord_u;
      coord_type coord_v;
      logic      zero_dir;
   } face_coord_type;

   // scoreboard: predicts each accepted direction, checks results in order
   class face_coord_board_type;
      face_coord_type pending_q[$];
      int             errors;
      int             checked;
      int             face_hits[6];
      int             zero_hits;
      int             sat_hits;

      // ratio num/den mapped to floor((ratio + 1) * half), saturated at all ones
      function coord_type fold_ratio(longint num, longint den);
         longint half_scale;
         longint top;
         longint q;
         half_scale = longint'(1) << (COORD_BITS - 1);
         top        = (longint'(1) << COORD_BITS) - 1;
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         q = ((num + den) * half_scale) / den;
         if (q > top) begin
            q = top;
            sat_hits++;
         end
         return coord_type'(q);
      endfunction

      function face_coord_type predict_face(comp_type dx, comp_type dy, comp_type dz);
         face_coord_type w;
         longint x, y, z, ax, ay, az;
         x  = longint'(dx);
         y  = longint'(dy);
         z  = longint'(dz);
         ax = (x < 0) ? -x : x;
         ay = (y < 0) ? -y : y;
         az = (z < 0) ? -z : z;
         w.zero_dir = (x == 0 && y == 0 && z == 0);
         // x wins ties over y and z, y wins over z
         if (ax >= ay && ax >= az) begin
            w.face = (x >= 0) ? FACE_POS_X : FACE_NEG_X;
            if (w.zero_dir) begin
               w.coord_u = coord_type'(longint'(1) << (COORD_BITS - 1));
               w.coord_v = w.coord_u;
            end else begin
               w.coord_u = fold_ratio(-z, x);
               w.coord_v = fold_ratio(y, ax);
            end
         end else if (ay >= az) begin
            w.face    = (y >= 0) ? FACE_POS_Y : FACE_NEG_Y;
            w.coord_u = fold_ratio(x, ay);
            w.coord_v = fold_ratio(-z, y);
         end else begin
            w.face    = (z >= 0) ? FACE_POS_Z : FACE_NEG_Z;
            w.coord_u = fold_ratio(x, z);
            w.coord_v = fold_ratio(y, az);
         end
         return w;
      endfunction

      function void note_dir(comp_type dx, comp_type dy, comp_type dz);
         face_coord_type w;
         w = predict_face(dx, dy, dz);
         face_hits[int'(w.face)]++;
         if (w.zero_dir) zero_hits++;
         pending_q.push_back(w);
      endfunction

      function void check_word(logic [FACE_BITS-1:0] face, coord_type u, coord_type v,
                               logic zero);
         face_coord_type w;
         checked++;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word face=%0d u=%0d v=%0d zero=%0b",
                     $time, face, u, v, zero);
            return;
         end
         w = pending_q.pop_front();
         if (face !== w.face || u !== w.coord_u || v !== w.coord_v || zero !== w.zero_dir)
         begin
            errors++;
            $display("%0t: expected face=%0d u=%0d v=%0d zero=%0b, got face=%0d u=%0d v=%0d zero=%0b",
                     $time, w.face, w.coord_u, w.coord_v, w.zero_dir, face, u, v, zero);
         end
      endfunction

      function int pending();
         return pending_q.size();
      endfunction
   endclass

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   comp_type  req_dir_x = '0;
   comp_type  req_dir_y = '0;
   comp_type  req_dir_z = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   logic [FACE_BITS-1:0] rsp_face;
   coord_type rsp_coord_u;
   coord_type rsp_coord_v;
   logic      rsp_zero_dir;

   // percent chance per cycle that the sender idles / the receiver stalls
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;

   face_coord_board_type board = new();

   cubemap_face_select_uv_unit #(
      .COMPONENT_BITS(COMPONENT_BITS),
      .COORD_BITS    (COORD_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_dir_x   (req_dir_x),
      .req_dir_y   (req_dir_y),
      .req_dir_z   (req_dir_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_face    (rsp_face),
      .rsp_coord_u (rsp_coord_u),
      .rsp_coord_v (rsp_coord_v),
      .rsp_zero_dir(rsp_zero_dir)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop far past the end of a normal run
   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: checks each taken word, then picks the next cycle's stall
   // sampling right after the edge sees the pre-edge values of every signal
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_word(rsp_face, rsp_coord_u, rsp_coord_v, rsp_zero_dir);
         rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // offer one direction word; returns at the edge where it was taken
   // valid stays high straight into the next word when there is no gap
   task automatic send_dir(comp_type dx, comp_type dy, comp_type dz);
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dir_x <= dx;
      req_dir_y <= dy;
      req_dir_z <= dz;
      do @(posedge clock); while (req_stall);
      board.note_dir(dx, dy, dz);
   endtask

   // stop sending until the pipeline has drained completely
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // random direction, weighted toward ties, extremes and ratios near +-1
   task automatic pick_dir(output comp_type dx, output comp_type dy, output comp_type dz);
      comp_type extremes[6];
      int       m;
      int       sel;
      extremes = '{comp_type'(-32768), comp_type'(-32767), comp_type'(-1), comp_type'(0),
                   comp_type'(1), comp_type'(32767)};
      dx = comp_type'($urandom);
      dy = comp_type'($urandom);
      dz = comp_type'($urandom);
      sel = $urandom_range(0, 9);
      case (sel)
         4: begin
            // tiny components: zero vectors and coarse ratios
            dx = comp_type'($urandom_range(0, 6) - 3);
            dy = comp_type'($urandom_range(0, 6) - 3);
            dz = comp_type'($urandom_range(0, 6) - 3);
         end
         5: begin
            // equal magnitudes with random signs exercise the tie rule
            m  = $urandom_range(0, 32767);
            dx = $urandom_range(0, 1) ? comp_type'(m) : comp_type'(-m);
            dy = $urandom_range(0, 1) ? comp_type'(m) : comp_type'(-m);
            dz = $urandom_range(0, 1) ? comp_type'(m) : comp_type'($urandom_range(0, m));
            if ($urandom_range(0, 2) == 0) dx = comp_type'(-32768);
         end
         6: begin
            dx = extremes[$urandom_range(0, 5)];
            dy = extremes[$urandom_range(0, 5)];
            dz = extremes[$urandom_range(0, 5)];
         end
         7: begin
            // minor components close to the major one, ratios near +-1
            m  = $urandom_range(1, 32767);
            dx = comp_type'(m - $urandom_range(0, 1));
            dy = comp_type'(m - $urandom_range(0, 2));
            dz = comp_type'(m - $urandom_range(0, 2));
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            if ($urandom_range(0, 1)) dz = -dz;
         end
         default: ;
      endcase
   endtask

   // main sequence: reset, directed words, then random words in idling phases
   initial begin
      comp_type dx, dy, dz;
      int       phase;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero vector, each face at full scale, most negative values
      send_dir(0, 0, 0);
      send_dir(32767, 0, 0);
      send_dir(-32768, 0, 0);
      send_dir(0, 32767, 0);
      send_dir(0, -32768, 0);
      send_dir(0, 0, 32767);
      send_dir(0, 0, -32768);
      // tie rule: x over y and z, y over z
      send_dir(100, -100, 100);
      send_dir(-7, 7, -7);
      send_dir(0, -50, 50);
      send_dir(3, 9, -9);
      send_dir(-32768, -32768, -32768);
      // ratios of exactly +1 saturate, exactly -1 give zero
      send_dir(1000, 0, -1000);
      send_dir(1000, 1000, 0);
      send_dir(-32768, 32767, 32767);
      send_dir(5, -5, 5);
      send_dir(32767, -32768, 1);
      send_dir(-1, -1, 32767);
      send_dir(1, 0, 0);
      send_dir(0, 0, -1);
      send_dir(-32767, 12345, -32768);
      send_dir(-1, -1, -1);

      // random words: 100-word phases cycling through the idling patterns
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            phase = (n / 100) % 4;
            case (phase)
               0: begin
                  sender_idle_pct = 0;
                  recv_stall_pct  = 0;
               end
               1: begin
                  sender_idle_pct = 56;
                  recv_stall_pct  = 0;
               end
               2: begin
                  sender_idle_pct = 0;
                  recv_stall_pct  = 56;
               end
               default: begin
                  sender_idle_pct = 18;
                  recv_stall_pct  = 18;
               end
            endcase
         end
         // one full drain mid-run so the pipeline restarts from empty
         if (n == RANDOM_WORDS / 2) wait_for_results();
         pick_dir(dx, dy, dz);
         send_dir(dx, dy, dz);
      end

      wait_for_results();
      // extra cycles to catch any stray result word after the last one
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      $display("run covered %0d result words: faces +x -x +y -y +z -z = %0d %0d %0d %0d %0d %0d",
               board.checked, board.face_hits[0], board.face_hits[1], board.face_hits[2],
               board.face_hits[3], board.face_hits[4], board.face_hits[5]);
      $display("zero vectors %0d, saturated coordinates %0d, mismatches %0d",
               board.zero_hits, board.sat_hits, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
